/* design/dtg_pkg.sv */
// Shared constants, calendar tables and stage bundle types for the date and time
// to GPS week converter.
// No dependencies; every other design file imports this package.
package dtg_pkg;

  // Field widths of the ports.
  localparam int DateW   = 20;
  localparam int TimeW   = 30;
  localparam int WeekW   = 13;
  localparam int MillisW = 30;
  localparam int LeapW   = 6;

  // Reset value of the leap second register.
  localparam logic [LeapW-1:0] LeapReset = 6'd18;

  // Reciprocal constants for division by constants.
  // For x < 2^Shift / (Recip * d - 2^Shift) the quotient (x * Recip) >> Shift is exact.
  localparam logic [20:0] Recip100  = 21'd1342178;     // 2^27 / 100, rounded up
  localparam logic [30:0] Recip1000 = 31'd1099511628;  // 2^40 / 1000, rounded up
  localparam logic [16:0] Recip7    = 17'd74899;       // 2^19 / 7, rounded up

  // Days from the GPS epoch (6 January 1980) to 1 January 2000.
  localparam logic [15:0] GpsDayBase  = 16'd7300;
  localparam logic [19:0] SecsPerDay  = 20'd86400;
  localparam logic [19:0] SecsPerWeek = 20'd604800;

  // Decimal fields after the digit split.
  typedef struct packed {
    logic [6:0] yy;
    logic [6:0] mon;
    logic [6:0] day;
    logic [6:0] hour;
    logic [6:0] min;
    logic [6:0] sec;
    logic [9:0] msec;
  } dtg_fields_t;

  // Day count and time of day, ready for the week split.
  typedef struct packed {
    logic        ok;
    logic [15:0] gps_days;
    logic [16:0] tod;
    logic [9:0]  msec;
  } dtg_day_t;

  // Days in the year before the first of the month (non-leap year).
  function automatic logic [8:0] month_start(input logic [6:0] mon);
    logic [8:0] res;
    unique case (mon)
      7'd1:    res = 9'd0;
      7'd2:    res = 9'd31;
      7'd3:    res = 9'd59;
      7'd4:    res = 9'd90;
      7'd5:    res = 9'd120;
      7'd6:    res = 9'd151;
      7'd7:    res = 9'd181;
      7'd8:    res = 9'd212;
      7'd9:    res = 9'd243;
      7'd10:   res = 9'd273;
      7'd11:   res = 9'd304;
      7'd12:   res = 9'd334;
      default: res = 9'd0;
    endcase
    return res;
  endfunction

  // Length of the month; a month code outside 1..12 gives zero.
  function automatic logic [4:0] month_len(input logic [6:0] mon, input logic leap);
    logic [4:0] res;
    unique case (mon)
      7'd1, 7'd3, 7'd5, 7'd7, 7'd8, 7'd10, 7'd12: res = 5'd31;
      7'd4, 7'd6, 7'd9, 7'd11:                    res = 5'd30;
      7'd2:                                       res = leap ? 5'd29 : 5'd28;
      default:                                    res = 5'd0;
    endcase
    return res;
  endfunction

endpackage

/* design/decimal_date_time_to_gps_week_top.sv */
// The done strobe follows the start beat through the pipeline stages (4 split stages,
// 1 day count stage, 3 week stages). Throughput: one beat per cycle, so busy is always low.
// The receiver cannot stall; every result is on the outputs for exactly one cycle.
// Reset (rst, synchronous, active high) empties the pipeline and sets leap_seconds to 18.
// Depends on dtg_pkg, dtg_split, dtg_days and dtg_week.
module decimal_date_time_to_gps_week_top (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic [dtg_pkg::DateW-1:0]   date_word,
  input  logic [dtg_pkg::TimeW-1:0]   time_word,
  input  logic                        cfg_wr_en,
  input  logic [dtg_pkg::LeapW-1:0]   cfg_wr_data,
  output logic                        done,
  output logic [dtg_pkg::WeekW-1:0]   gps_week,
  output logic [dtg_pkg::MillisW-1:0] week_millis,
  output logic                        valid_res
);
  import dtg_pkg::*;

  logic [LeapW-1:0] leap_seconds;
  logic             split_vld;
  dtg_fields_t      fields;
  logic             days_vld;
  dtg_day_t         day_info;

  // The pipeline takes a new beat every cycle.
  assign busy = 1'b0;

  // Leap second register.
  always_ff @(posedge clk) begin
    if (rst) begin
      leap_seconds <= LeapReset;
    end else if (cfg_wr_en) begin
      leap_seconds <= cfg_wr_data;
    end
  end

  dtg_split u_split (
    .clk       (clk),
    .rst       (rst),
    .in_vld    (start && !busy),
    .date_word (date_word),
    .time_word (time_word),
    .out_vld   (split_vld),
    .fields    (fields)
  );

  dtg_days u_days (
    .clk          (clk),
    .rst          (rst),
    .in_vld       (split_vld),
    .fields       (fields),
    .leap_seconds (leap_seconds),
    .out_vld      (days_vld),
    .day_info     (day_info)
  );

  dtg_week u_week (
    .clk         (clk),
    .rst         (rst),
    .in_vld      (days_vld),
    .day_info    (day_info),
    .out_vld     (done),
    .gps_week    (gps_week),
    .week_millis (week_millis),
    .valid_res   (valid_res)
  );

`ifndef SYNTHESIS
  // Every accepted beat gives its result strobe.
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##8 done)
    else $error("result strobe missing eight cycles after a start beat");

  // A strobe never appears without a matching accepted beat.
  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, 8))
    else $error("result strobe without a matching start beat");

  // Rejected fields give zero outputs.
  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    (done && !valid_res) |-> (gps_week == '0 && week_millis == '0))
    else $error("invalid result carries non-zero fields");

  // The millisecond of the week stays within one week.
  a_millis_range: assert property (@(posedge clk) disable iff (rst)
    done |-> (week_millis < 30'd604800000))
    else $error("week_millis beyond one week");
`endif

endmodule

/* design/dtg_split.sv */
// Four-stage decimal digit split of the packed date and time words.
// Depends on dtg_pkg for the reciprocal constants and the field bundle type.
module dtg_split (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_vld,
  input  logic [dtg_pkg::DateW-1:0] date_word,
  input  logic [dtg_pkg::TimeW-1:0] time_word,
  output logic                      out_vld,
  output dtg_pkg::dtg_fields_t      fields
);
  import dtg_pkg::*;

  // Stage 1: date / 100 and time / 1000.
  logic [40:0] date_prod;
  logic [60:0] time_prod;
  logic        s1_vld;
  logic [13:0] s1_q1;
  logic [6:0]  s1_date_lo;
  logic [20:0] s1_v;
  logic [9:0]  s1_time_lo;

  assign date_prod = 41'(date_word) * 41'(Recip100);
  assign time_prod = 61'(time_word) * 61'(Recip1000);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld <= 1'b0;
    end else begin
      s1_vld <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    s1_q1      <= date_prod[40:27];
    s1_date_lo <= date_word[6:0];
    s1_v       <= time_prod[60:40];
    s1_time_lo <= time_word[9:0];
  end

  // Stage 2: year and millisecond remainders, day and (time / 100000).
  logic [34:0] q1_prod;
  logic [41:0] v_prod;
  logic        s2_vld;
  logic [6:0]  s2_yy;
  logic [6:0]  s2_q1_lo;
  logic [6:0]  s2_day;
  logic [6:0]  s2_v_lo;
  logic [13:0] s2_w;
  logic [9:0]  s2_msec;

  assign q1_prod = 35'(s1_q1) * 35'(Recip100);
  assign v_prod  = 42'(s1_v) * 42'(Recip100);

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_vld <= 1'b0;
    end else begin
      s2_vld <= s1_vld;
    end
  end

  // Remainders only need the low bits of the dividend and the quotient.
  always_ff @(posedge clk) begin
    s2_yy    <= 7'(s1_date_lo - 7'(s1_q1[6:0] * 7'd100));
    s2_q1_lo <= s1_q1[6:0];
    s2_day   <= q1_prod[33:27];
    s2_v_lo  <= s1_v[6:0];
    s2_w     <= v_prod[40:27];
    s2_msec  <= 10'(s1_time_lo - 10'(s1_v[9:0] * 10'd1000));
  end

  // Stage 3: month and second remainders, hour quotient.
  logic [34:0] w_prod;
  logic        s3_vld;
  logic [6:0]  s3_yy;
  logic [6:0]  s3_mon;
  logic [6:0]  s3_day;
  logic [6:0]  s3_sec;
  logic [6:0]  s3_hour;
  logic [6:0]  s3_w_lo;
  logic [9:0]  s3_msec;

  assign w_prod = 35'(s2_w) * 35'(Recip100);

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_vld <= 1'b0;
    end else begin
      s3_vld <= s2_vld;
    end
  end

  always_ff @(posedge clk) begin
    s3_yy   <= s2_yy;
    s3_mon  <= 7'(s2_q1_lo - 7'(s2_day * 7'd100));
    s3_day  <= s2_day;
    s3_sec  <= 7'(s2_v_lo - 7'(s2_w[6:0] * 7'd100));
    s3_hour <= w_prod[33:27];
    s3_w_lo <= s2_w[6:0];
    s3_msec <= s2_msec;
  end

  // Stage 4: minute remainder, all fields registered together.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else begin
      out_vld <= s3_vld;
    end
  end

  always_ff @(posedge clk) begin
    fields.yy   <= s3_yy;
    fields.mon  <= s3_mon;
    fields.day  <= s3_day;
    fields.hour <= s3_hour;
    fields.min  <= 7'(s3_w_lo - 7'(s3_hour * 7'd100));
    fields.sec  <= s3_sec;
    fields.msec <= s3_msec;
  end

endmodule

/* design/dtg_days.sv */
// Range checks, day count from the GPS epoch and seconds of the day.
// Depends on dtg_pkg for the calendar tables and the bundle types.
module dtg_days (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_vld,
  input  dtg_pkg::dtg_fields_t      fields,
  input  logic [dtg_pkg::LeapW-1:0] leap_seconds,
  output logic                      out_vld,
  output dtg_pkg::dtg_day_t         day_info
);
  import dtg_pkg::*;

  logic        leap_yr;
  logic [4:0]  mlen;
  logic        ok_date;
  logic        ok_time;
  logic [7:0]  yy_plus3;
  logic [15:0] leap_days;
  logic [15:0] gps_days;
  logic [16:0] tod;

  // Every fourth year from 2000 is a leap year in this range.
  assign leap_yr = (fields.yy[1:0] == 2'd0);
  assign mlen    = month_len(fields.mon, leap_yr);

  // An invalid month gives a zero length, so the day check fails too.
  assign ok_date = (fields.day != 7'd0) && (fields.day <= 7'(mlen));
  assign ok_time = (fields.hour <= 7'd23) && (fields.min <= 7'd59) && (fields.sec <= 7'd59);

  // Whole days since 6 January 1980.
  assign yy_plus3  = 8'(fields.yy) + 8'd3;
  assign leap_days = 16'(yy_plus3[7:2]) + ((leap_yr && (fields.mon > 7'd2)) ? 16'd1 : 16'd0);
  assign gps_days  = GpsDayBase + 16'(fields.yy) * 16'd365 + leap_days
                   + 16'(month_start(fields.mon)) + 16'(fields.day) - 16'd1;

  // Seconds of the day with the leap second offset folded in.
  assign tod = 17'(fields.hour) * 17'd3600 + 17'(fields.min) * 17'd60
             + 17'(fields.sec) + 17'(leap_seconds);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else begin
      out_vld <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    day_info.ok       <= ok_date && ok_time;
    day_info.gps_days <= gps_days;
    day_info.tod      <= tod;
    day_info.msec     <= fields.msec;
  end

endmodule

/* design/dtg_week.sv */
// Three-stage split of the day count into GPS week and millisecond of week.
// Depends on dtg_pkg for the reciprocal of seven, the week length and the bundle type.
module dtg_week (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_vld,
  input  dtg_pkg::dtg_day_t           day_info,
  output logic                        out_vld,
  output logic [dtg_pkg::WeekW-1:0]   gps_week,
  output logic [dtg_pkg::MillisW-1:0] week_millis,
  output logic                        valid_res
);
  import dtg_pkg::*;

  // Stage 1: week = days / 7.
  logic [32:0]      days_prod;
  logic             s1_vld;
  logic             s1_ok;
  logic [WeekW-1:0] s1_week;
  logic [2:0]       s1_days_lo;
  logic [16:0]      s1_tod;
  logic [9:0]       s1_msec;

  assign days_prod = 33'(day_info.gps_days) * 33'(Recip7);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld <= 1'b0;
    end else begin
      s1_vld <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    s1_ok      <= day_info.ok;
    s1_week    <= days_prod[31:19];
    s1_days_lo <= day_info.gps_days[2:0];
    s1_tod     <= day_info.tod;
    s1_msec    <= day_info.msec;
  end

  // Stage 2: second of week; the leap offset may carry into the next week.
  logic [2:0]       dow;
  logic [19:0]      sow_raw;
  logic             s2_vld;
  logic             s2_ok;
  logic [WeekW-1:0] s2_week;
  logic [19:0]      s2_sow;
  logic [9:0]       s2_msec;

  assign dow     = 3'(s1_days_lo - 3'(s1_week[2:0] * 3'd7));
  assign sow_raw = 20'(dow) * SecsPerDay + 20'(s1_tod);

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_vld <= 1'b0;
    end else begin
      s2_vld <= s1_vld;
    end
  end

  always_ff @(posedge clk) begin
    s2_ok   <= s1_ok;
    s2_msec <= s1_msec;
    if (sow_raw >= SecsPerWeek) begin
      s2_week <= s1_week + 13'd1;
      s2_sow  <= sow_raw - SecsPerWeek;
    end else begin
      s2_week <= s1_week;
      s2_sow  <= sow_raw;
    end
  end

  // Stage 3: milliseconds of week and the zeroed result for bad fields.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else begin
      out_vld <= s2_vld;
    end
  end

  always_ff @(posedge clk) begin
    valid_res <= s2_ok;
    if (s2_ok) begin
      gps_week    <= s2_week;
      week_millis <= 30'(s2_sow) * 30'd1000 + 30'(s2_msec);
    end else begin
      gps_week    <= '0;
      week_millis <= '0;
    end
  end

endmodule

/* bench/tb.sv */
// Self-checking bench for the UTC date and time to GPS week converter: a queued driver, a
// result monitor and a per-beat prediction of week and millisecond of week.
// Depends on dtg_pkg and decimal_date_time_to_gps_week_top.
module tb;
  import dtg_pkg::*;

  localparam int CycleLimit = 400000;
  localparam int DrainCycles = 16;

  // Kinds of entry in the queue of pending stimulus.
  typedef enum logic [1:0] {
    OP_CONVERT,
    OP_SET_LEAP,
    OP_QUIESCE
  } op_kind_t;

  typedef struct {
    op_kind_t          kind;
    logic [DateW-1:0]  date;
    logic [TimeW-1:0]  tod;
    logic [LeapW-1:0]  leap;
    bit                may_idle;
  } pend_t;

  typedef struct packed {
    logic [WeekW-1:0]   week;
    logic [MillisW-1:0] millis;
    logic               valid;
  } gps_res_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               start = 1'b0;
  logic               busy;
  logic [DateW-1:0]   date_word = '0;
  logic [TimeW-1:0]   time_word = '0;
  logic               cfg_wr_en = 1'b0;
  logic [LeapW-1:0]   cfg_wr_data = '0;
  logic               done;
  logic [WeekW-1:0]   gps_week;
  logic [MillisW-1:0] week_millis;
  logic               valid_res;

  pend_t        pend_q[$];
  gps_res_t     gps_exp_q[$];
  logic [LeapW-1:0] leap_model = LeapReset;
  int unsigned  gap_left = 0;
  bit           stim_done = 1'b0;
  int unsigned  fail_cnt = 0;
  int unsigned  cycle_cnt = 0;

  decimal_date_time_to_gps_week_top u_top (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .date_word   (date_word),
    .time_word   (time_word),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .done        (done),
    .gps_week    (gps_week),
    .week_millis (week_millis),
    .valid_res   (valid_res)
  );

  // Days in a month of year 2000+yy; only meaningful for months 1 to 12.
  function automatic int unsigned days_in_month(int unsigned mon, int unsigned yy);
    case (mon)
      4, 6, 9, 11: return 30;
      2:           return (yy % 4 == 0) ? 29 : 28;
      default:     return 31;
    endcase
  endfunction

  // Expected week and millisecond of week for one date and time beat.
  function automatic gps_res_t utc_to_gps(logic [DateW-1:0] date, logic [TimeW-1:0] tod,
                                          logic [LeapW-1:0] leap_s);
    gps_res_t r;
    longint unsigned yy, mon, day, hh, mi, ss, ms, v, days, secs;
    r = '0;
    yy = date % 100;
    mon = (date / 100) % 100;
    day = date / 10000;
    v = tod;
    ms = v % 1000;
    v = v / 1000;
    ss = v % 100;
    v = v / 100;
    mi = v % 100;
    hh = v / 100;
    if (mon < 1 || mon > 12 || day < 1 || day > days_in_month(32'(mon), 32'(yy)) ||
        hh > 23 || mi > 59 || ss > 59) begin
      return r;
    end
    // Whole days since 1970; summing the month lengths takes care of the leap day.
    days = 10957 + 365 * yy + (yy + 3) / 4 + day - 1;
    for (int m = 1; m < mon; m++) begin
      days += days_in_month(m, 32'(yy));
    end
    secs = days * 86400 + hh * 3600 + mi * 60 + ss + leap_s - 64'd315964800;
    r.week = WeekW'(secs / 604800);
    r.millis = MillisW'((secs % 604800) * 1000 + ms);
    r.valid = 1'b1;
    return r;
  endfunction

  function automatic logic [DateW-1:0] mk_date(int unsigned dd, int unsigned mm,
                                               int unsigned yy);
    return DateW'(dd * 10000 + mm * 100 + yy);
  endfunction

  function automatic logic [TimeW-1:0] mk_time(int unsigned hh, int unsigned mi,
                                               int unsigned ss, int unsigned ms);
    return TimeW'(((hh * 100 + mi) * 100 + ss) * 1000 + ms);
  endfunction

  task automatic push_convert(logic [DateW-1:0] date, logic [TimeW-1:0] tod, bit may_idle);
    pend_t p;
    p.kind = OP_CONVERT;
    p.date = date;
    p.tod = tod;
    p.leap = '0;
    p.may_idle = may_idle;
    pend_q.push_back(p);
  endtask

  task automatic push_ctrl(op_kind_t kind, logic [LeapW-1:0] leap);
    pend_t p;
    p.kind = kind;
    p.date = '0;
    p.tod = '0;
    p.leap = leap;
    p.may_idle = 1'b0;
    pend_q.push_back(p);
  endtask

  // Clock.
  initial begin
    forever #5 clk = ~clk;
  end

  // Run length guard.
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CycleLimit) begin
      $display("FAIL");
      $finish;
    end
  end

  // Driver: records each accepted beat, then presents the next entry of the queue.
  always @(posedge clk) begin : drive_proc
    logic  nxt_start;
    logic  nxt_wr;
    pend_t head;
    nxt_start = 1'b0;
    nxt_wr = 1'b0;
    if (!rst) begin
      if (start && !busy) begin
        gps_exp_q.push_back(utc_to_gps(date_word, time_word, leap_model));
      end
      if (cfg_wr_en) begin
        leap_model = cfg_wr_data;
      end
      if (start && busy) begin
        nxt_start = 1'b1;
      end else if (gap_left != 0) begin
        gap_left--;
      end else if (pend_q.size() != 0) begin
        head = pend_q[0];
        case (head.kind)
          OP_CONVERT: begin
            nxt_start = 1'b1;
            date_word <= head.date;
            time_word <= head.tod;
            void'(pend_q.pop_front());
            if (head.may_idle && $urandom_range(0, 5) == 0) begin
              gap_left = $urandom_range(1, 14);
            end
          end
          OP_SET_LEAP: begin
            // The register is only touched once the pipeline has emptied.
            if (gps_exp_q.size() == 0 && !done) begin
              nxt_wr = 1'b1;
              cfg_wr_data <= head.leap;
              void'(pend_q.pop_front());
            end
          end
          default: begin
            if (gps_exp_q.size() == 0 && !done) begin
              void'(pend_q.pop_front());
            end
          end
        endcase
      end else begin
        stim_done = 1'b1;
      end
    end
    start <= nxt_start;
    cfg_wr_en <= nxt_wr;
  end

  // Monitor: every done strobe is checked against the oldest expectation.
  always @(posedge clk) begin : mon_proc
    gps_res_t want;
    if (!rst && done) begin
      if (gps_exp_q.size() == 0) begin
        $display("%0t: result with nothing expected: week %0d millis %0d valid %0b",
                 $time, gps_week, week_millis, valid_res);
        fail_cnt++;
      end else begin
        want = gps_exp_q.pop_front();
        if (gps_week !== want.week) begin
          $display("%0t: gps_week mismatch: expected %0d actual %0d",
                   $time, want.week, gps_week);
          fail_cnt++;
        end
        if (week_millis !== want.millis) begin
          $display("%0t: week_millis mismatch: expected %0d actual %0d",
                   $time, want.millis, week_millis);
          fail_cnt++;
        end
        if (valid_res !== want.valid) begin
          $display("%0t: valid_res mismatch: expected %0b actual %0b",
                   $time, want.valid, valid_res);
          fail_cnt++;
        end
      end
    end
  end

  // Stimulus plan, reset and end of run.
  initial begin : plan_proc
    int unsigned yy, mm, dd, hh, mi, ss, ms, len, pick;
    bit          idle_ok;
    logic [LeapW-1:0] leap_v;

    // Directed beats at the reset value of the leap second register.
    push_convert(mk_date(1, 1, 0), mk_time(0, 0, 0, 0), 1'b1);
    push_convert(mk_date(31, 12, 99), mk_time(23, 59, 59, 999), 1'b1);
    push_convert(mk_date(29, 2, 0), mk_time(12, 34, 56, 789), 1'b1);
    push_convert(mk_date(29, 2, 1), mk_time(12, 0, 0, 0), 1'b1);
    push_convert(mk_date(28, 2, 1), mk_time(23, 59, 59, 999), 1'b1);
    push_convert(mk_date(29, 2, 96), mk_time(0, 0, 0, 1), 1'b1);
    push_convert(mk_date(1, 3, 0), mk_time(0, 0, 0, 0), 1'b1);
    push_convert(mk_date(1, 3, 1), mk_time(0, 0, 0, 0), 1'b1);
    push_convert(mk_date(0, 1, 10), mk_time(1, 2, 3, 4), 1'b1);
    push_convert(mk_date(1, 0, 10), mk_time(1, 2, 3, 4), 1'b1);
    push_convert(mk_date(1, 13, 10), mk_time(1, 2, 3, 4), 1'b1);
    push_convert(mk_date(31, 4, 99), mk_time(6, 0, 0, 0), 1'b1);
    push_convert(mk_date(30, 4, 99), mk_time(6, 0, 0, 0), 1'b1);
    push_convert(mk_date(31, 1, 99), mk_time(6, 0, 0, 0), 1'b1);
    push_convert(mk_date(15, 6, 50), mk_time(24, 0, 0, 0), 1'b1);
    push_convert(mk_date(15, 6, 50), mk_time(0, 60, 0, 0), 1'b1);
    push_convert(mk_date(30, 6, 50), mk_time(23, 59, 60, 0), 1'b1);
    push_convert(mk_date(15, 6, 50), {TimeW{1'b1}}, 1'b1);
    push_convert(mk_date(15, 6, 50), 30'd999999999, 1'b1);
    push_convert({DateW{1'b1}}, mk_time(10, 0, 0, 0), 1'b1);
    push_convert(20'd999999, mk_time(10, 0, 0, 0), 1'b1);
    push_convert('0, '0, 1'b1);
    push_convert(mk_date(6, 1, 80), mk_time(0, 0, 0, 0), 1'b1);
    push_convert(mk_date(5, 1, 80), mk_time(23, 59, 41, 999), 1'b1);

    // Random phases, each behind a full drain and a new leap second setting.
    for (int p = 0; p < 7; p++) begin
      leap_v = (p == 0) ? 6'd0 : (p == 1) ? 6'd63 : LeapW'($urandom_range(0, 63));
      idle_ok = (p != 3 && p != 6);
      push_ctrl(OP_QUIESCE, '0);
      push_ctrl(OP_SET_LEAP, leap_v);
      for (int i = 0; i < 150; i++) begin
        pick = $urandom_range(0, 99);
        if (pick < 15) begin
          push_convert(DateW'($urandom_range(0, 2**DateW - 1)),
                       TimeW'($urandom_range(0, 2**TimeW - 1)), idle_ok);
        end else begin
          // Well-formed date and time, with the extremes of each field favoured.
          yy = ($urandom_range(0, 7) == 0) ? 99 * $urandom_range(0, 1) : $urandom_range(0, 99);
          mm = $urandom_range(1, 12);
          len = days_in_month(mm, yy);
          dd = ($urandom_range(0, 3) == 0) ? (($urandom_range(0, 1) != 0) ? len : 1)
                                           : $urandom_range(1, len);
          hh = ($urandom_range(0, 7) == 0) ? 23 : $urandom_range(0, 23);
          mi = ($urandom_range(0, 7) == 0) ? 59 : $urandom_range(0, 59);
          ss = ($urandom_range(0, 7) == 0) ? 59 : $urandom_range(0, 59);
          ms = ($urandom_range(0, 7) == 0) ? 999 : $urandom_range(0, 999);
          // Some beats get one field pushed out of range.
          if (pick < 27) begin
            case ($urandom_range(0, 5))
              0:       dd = 0;
              1:       dd = $urandom_range(len + 1, 99);
              2:       mm = ($urandom_range(0, 1) != 0) ? 0 : $urandom_range(13, 99);
              3:       hh = $urandom_range(24, 99);
              4:       mi = $urandom_range(60, 99);
              default: ss = $urandom_range(60, 99);
            endcase
          end
          push_convert(mk_date(dd, mm, yy), mk_time(hh, mi, ss, ms), idle_ok);
        end
      end
    end

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    wait (stim_done);
    while (gps_exp_q.size() != 0) begin
      @(posedge clk);
    end
    repeat (DrainCycles) @(posedge clk);
    if (fail_cnt == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
